@@ design/cot_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cot_pkg
// Shared types and constants of the clock offset table.
// ----------------------------------------------------------------------------
package cot_pkg;

  localparam int unsigned IdW     = 16;
  localparam int unsigned RatioW  = 32;
  localparam int unsigned FactorW = 33;
  localparam int unsigned StatusW = 3;

  // 1.0 in signed Q3.30
  localparam logic signed [FactorW-1:0] Q30One = FactorW'(64'sd1 << 30);

  typedef enum logic [StatusW-1:0] {
    StUpdated  = 3'd0,
    StInserted = 3'd1,
    StDropped  = 3'd2,
    StFound    = 3'd3,
    StNotFound = 3'd4
  } status_e;

  typedef enum logic {
    CmdSet = 1'b0,
    CmdGet = 1'b1
  } cmd_e;

  // write request from the sequencer to the entry store
  typedef struct packed {
    logic                     ratio_we;
    logic                     id_we;
    logic [IdW-1:0]           id;
    logic signed [RatioW-1:0] ratio;
  } store_wr_t;

endpackage

@@ design/cot_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cot_if
// Valid/ready channels for commands and responses of the clock offset table.
// ----------------------------------------------------------------------------
interface cot_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     cmd;
  logic [cot_pkg::IdW-1:0]                  agent_key;
  logic signed [cot_pkg::RatioW-1:0]        offset_ratio;

  modport source (output valid, cmd, agent_key, offset_ratio, input ready);
  modport sink   (input valid, cmd, agent_key, offset_ratio, output ready);
endinterface

interface cot_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [cot_pkg::StatusW-1:0]              status;
  logic signed [cot_pkg::FactorW-1:0]       factor;

  modport source (output valid, status, factor, input ready);
  modport sink   (input valid, status, factor, output ready);
endinterface

@@ design/cot_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cot_store
// Entry memories (id and ratio) with one registered read port, one write
// port and per-entry valid bits so an entry never written reads as empty.
// ----------------------------------------------------------------------------
module cot_store #(
  parameter int unsigned ENTRIES = 32,
  parameter int unsigned IW      = 5
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [IW-1:0]                        rd_addr_i,
  output logic [cot_pkg::IdW-1:0]              rd_id_o,
  output logic signed [cot_pkg::RatioW-1:0]    rd_ratio_o,
  input  logic [IW-1:0]                        wr_addr_i,
  input  cot_pkg::store_wr_t                   wr_i
);

  logic [cot_pkg::IdW-1:0]           id_mem    [ENTRIES];
  logic signed [cot_pkg::RatioW-1:0] ratio_mem [ENTRIES];
  logic [ENTRIES-1:0]                vld_q;
  logic [cot_pkg::IdW-1:0]           id_rd_q;
  logic signed [cot_pkg::RatioW-1:0] ratio_rd_q;
  logic                              vld_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.id_we) begin
      id_mem[wr_addr_i] <= wr_i.id;
    end
    if (wr_i.ratio_we) begin
      ratio_mem[wr_addr_i] <= wr_i.ratio;
    end
    id_rd_q    <= id_mem[rd_addr_i];
    ratio_rd_q <= ratio_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (wr_i.id_we) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      vld_rd_q <= vld_q[rd_addr_i];
    end
  end

  // an entry never written is empty with a zero ratio
  assign rd_id_o    = vld_rd_q ? id_rd_q : '0;
  assign rd_ratio_o = vld_rd_q ? ratio_rd_q : '0;

endmodule

@@ design/cot_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cot_ctrl
// Scan sequencer: walks the entries one per cycle through the shared id
// compare, computes the correction factor and holds the response register.
// ----------------------------------------------------------------------------
module cot_ctrl #(
  parameter int unsigned ENTRIES = 32,
  parameter int unsigned IW      = 5
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  cot_in_if.sink                               in_i,
  cot_out_if.source                            out_o,
  output logic [IW-1:0]                        rd_addr_o,
  input  logic [cot_pkg::IdW-1:0]              rd_id_i,
  input  logic signed [cot_pkg::RatioW-1:0]    rd_ratio_i,
  output logic [IW-1:0]                        wr_addr_o,
  output cot_pkg::store_wr_t                   wr_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StResp
  } state_e;

  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

  state_e                             state_q;
  logic [IW-1:0]                      idx_q;
  logic                               cmd_q;
  logic [cot_pkg::IdW-1:0]            key_q;
  logic signed [cot_pkg::RatioW-1:0]  ratio_q;
  logic [cot_pkg::StatusW-1:0]        res_status_q;
  logic signed [cot_pkg::FactorW-1:0] res_factor_q;
  logic                               out_valid_q;
  logic [cot_pkg::StatusW-1:0]        out_status_q;
  logic signed [cot_pkg::FactorW-1:0] out_factor_q;
  logic                               hit;
  logic                               empty;
  logic                               last;
  logic signed [cot_pkg::FactorW-1:0] diff;

  assign hit   = (rd_id_i == key_q);
  assign empty = (rd_id_i == '0);
  assign last  = (idx_q == LastIdx);
  assign diff  = cot_pkg::Q30One - cot_pkg::FactorW'(rd_ratio_i);

  // read address runs one ahead of the entry being compared
  assign rd_addr_o = (state_q == StScan) ? IW'(idx_q + 1'b1) : '0;
  assign wr_addr_o = idx_q;

  always_comb begin
    wr_o          = '0;
    wr_o.id       = key_q;
    wr_o.ratio    = ratio_q;
    if (state_q == StScan && cmd_q == cot_pkg::CmdSet) begin
      wr_o.ratio_we = hit || empty;
      wr_o.id_we    = empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      idx_q        <= '0;
      cmd_q        <= cot_pkg::CmdSet;
      key_q        <= '0;
      ratio_q      <= '0;
      res_status_q <= cot_pkg::StUpdated;
      res_factor_q <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= cot_pkg::StUpdated;
      out_factor_q <= '0;
    end else begin
      if (out_o.ready && state_q != StResp) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            cmd_q   <= in_i.cmd;
            key_q   <= in_i.agent_key;
            ratio_q <= in_i.offset_ratio;
            idx_q   <= '0;
            if (in_i.agent_key == '0) begin
              // reserved id never matches and never gets inserted
              if (in_i.cmd == cot_pkg::CmdGet) begin
                res_status_q <= cot_pkg::StNotFound;
                res_factor_q <= cot_pkg::Q30One;
              end else begin
                res_status_q <= cot_pkg::StDropped;
                res_factor_q <= '0;
              end
              state_q <= StResp;
            end else begin
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          if (cmd_q == cot_pkg::CmdSet) begin
            res_factor_q <= '0;
            if (hit) begin
              res_status_q <= cot_pkg::StUpdated;
              state_q      <= StResp;
            end else if (empty) begin
              res_status_q <= cot_pkg::StInserted;
              state_q      <= StResp;
            end else if (last) begin
              res_status_q <= cot_pkg::StDropped;
              state_q      <= StResp;
            end else begin
              idx_q <= IW'(idx_q + 1'b1);
            end
          end else begin
            if (hit) begin
              res_status_q <= cot_pkg::StFound;
              res_factor_q <= diff;
              state_q      <= StResp;
            end else if (last) begin
              res_status_q <= cot_pkg::StNotFound;
              res_factor_q <= cot_pkg::Q30One;
              state_q      <= StResp;
            end else begin
              idx_q <= IW'(idx_q + 1'b1);
            end
          end
        end
        StResp: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_factor_q <= res_factor_q;
            state_q      <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_i.ready   = (state_q == StIdle);
  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.factor = out_factor_q;

endmodule

@@ design/clock_offset_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_offset_table
// Associative table of per-agent clock offset ratios keyed by agent id.
// Operation: a command scans k entries (1..ENTRIES), one per cycle through the
//   single store read port; a reserved id skips the scan. The response is then
//   registered, held back while an earlier response is still unaccepted.
//   A new command is taken only once the previous response is registered.
// Reset: asynchronous, clears all entry valid bits at once, so the table is
//   empty and usable in the first cycle after reset.
// ----------------------------------------------------------------------------
module clock_offset_table #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cot_in_if.sink    in_i,
  cot_out_if.source out_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [IW-1:0]                     rd_addr;
  logic [IW-1:0]                     wr_addr;
  logic [cot_pkg::IdW-1:0]           rd_id;
  logic signed [cot_pkg::RatioW-1:0] rd_ratio;
  cot_pkg::store_wr_t                wr;

  cot_ctrl #(
    .ENTRIES(ENTRIES),
    .IW     (IW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .rd_addr_o (rd_addr),
    .rd_id_i   (rd_id),
    .rd_ratio_i(rd_ratio),
    .wr_addr_o (wr_addr),
    .wr_o      (wr)
  );

  cot_store #(
    .ENTRIES(ENTRIES),
    .IW     (IW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_id_o   (rd_id),
    .rd_ratio_o(rd_ratio),
    .wr_addr_i (wr_addr),
    .wr_i      (wr)
  );

endmodule

@@ test/clock_offset_table_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_offset_table_test
// Drives set and get commands into the offset table, keeps its own copy of
// the slot contents, and checks every response status and factor in order.
// ----------------------------------------------------------------------------
module clock_offset_table_test;

  localparam int unsigned Entries    = 32;
  localparam int unsigned NumRandom  = 1100;
  localparam int unsigned PoolSize   = 40;
  localparam int unsigned TailCycles = Entries + 8;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned HoldAfter  = 400;
  localparam longint unsigned CycleLimit = 600000;

  typedef struct {
    cot_pkg::cmd_e                     cmd;
    logic [cot_pkg::IdW-1:0]           agent_key;
    logic signed [cot_pkg::RatioW-1:0] ratio;
    bit                                drain_first;
  } command_t;

  typedef struct {
    cot_pkg::status_e                   status;
    logic signed [cot_pkg::FactorW-1:0] factor;
  } reply_t;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic hold_rx = 1'b0;

  cot_in_if  cmd_if ();
  cot_out_if rsp_if ();

  clock_offset_table #(
    .ENTRIES(Entries)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (rsp_if)
  );

  command_t cmd_q[$];
  reply_t   reply_q[$];

  logic [cot_pkg::IdW-1:0]           slot_id   [Entries];
  logic signed [cot_pkg::RatioW-1:0] slot_ratio[Entries];

  int unsigned     errors    = 0;
  int unsigned     cmds_sent = 0;
  longint unsigned cycles    = 0;

  always #1 clk_i = ~clk_i;

  // applies one command to the local slot copy and returns its response
  function automatic reply_t table_response(command_t c);
    reply_t r;
    bit     done;
    done     = 1'b0;
    r.factor = '0;
    if (c.cmd == cot_pkg::CmdSet) begin
      r.status = cot_pkg::StDropped;
      if (c.agent_key != '0) begin
        for (int i = 0; i < Entries; i++) begin
          if (!done && slot_id[i] == c.agent_key) begin
            slot_ratio[i] = c.ratio;
            r.status      = cot_pkg::StUpdated;
            done          = 1'b1;
          end else if (!done && slot_id[i] == '0) begin
            slot_id[i]    = c.agent_key;
            slot_ratio[i] = c.ratio;
            r.status      = cot_pkg::StInserted;
            done          = 1'b1;
          end
        end
      end
    end else begin
      r.status = cot_pkg::StNotFound;
      r.factor = cot_pkg::Q30One;
      if (c.agent_key != '0) begin
        for (int i = 0; i < Entries; i++) begin
          if (!done && slot_id[i] == c.agent_key) begin
            // 1.0 - ratio, exact in 33 bits
            r.factor = cot_pkg::FactorW'((longint'(1) << 30) - longint'(slot_ratio[i]));
            r.status = cot_pkg::StFound;
            done     = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic void add_cmd(cot_pkg::cmd_e c, logic [cot_pkg::IdW-1:0] id,
                                  logic signed [cot_pkg::RatioW-1:0] ratio,
                                  bit drain = 1'b0);
    command_t item;
    item.cmd         = c;
    item.agent_key   = id;
    item.ratio       = ratio;
    item.drain_first = drain;
    cmd_q.push_back(item);
  endfunction

  function automatic void note_error(string msg);
    errors++;
    $display("%0t: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------- driver
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  int          in_flight  = 0;
  command_t    cur;

  always @(posedge clk_i) begin : drive
    logic offering;
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else begin
      offering = cmd_if.valid;
      if (rsp_if.valid && rsp_if.ready) in_flight--;
      if (cmd_if.valid && cmd_if.ready) begin
        reply_q.push_back(table_response(cur));
        cmds_sent++;
        in_flight++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (cmd_q.size() != 0 && !(cmd_q[0].drain_first && in_flight != 0)) begin
          cur      = cmd_q.pop_front();
          offering = 1'b1;
          cmd_if.cmd          <= cur.cmd;
          cmd_if.agent_key    <= cur.agent_key;
          cmd_if.offset_ratio <= cur.ratio;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end
      end
      cmd_if.valid <= offering;
    end
  end

  // --------------------------------------------------------------- monitor
  int unsigned rx_tick = 0;

  always @(posedge clk_i) begin : monitor
    reply_t want;
    logic   rdy;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (reply_q.size() == 0) begin
          note_error($sformatf("unexpected response, expected none, actual status %0d factor %0d",
                               rsp_if.status, rsp_if.factor));
        end else begin
          want = reply_q.pop_front();
          if (rsp_if.status !== want.status)
            note_error($sformatf("status mismatch, expected %0d actual %0d",
                                 want.status, rsp_if.status));
          if (rsp_if.factor !== want.factor)
            note_error($sformatf("factor mismatch, expected %0d actual %0d",
                                 want.factor, rsp_if.factor));
        end
      end
      rx_tick++;
      // receiver mode rotates through four ready patterns, selected by rx_tick[8:7]
      case (rx_tick[8:7])
        2'd0:    rdy = 1'b1;
        2'd1:    rdy = $urandom_range(0, 1);
        2'd2:    rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (rx_tick[2:0] != 3'd0);
      endcase
      rsp_if.ready <= rdy && !hold_rx;
    end
  end

  // long receiver hold-off so the table backs up into the command channel
  initial begin : rx_hold
    wait (cmds_sent >= HoldAfter);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // -------------------------------------------------------------- stimulus
  initial begin : stimulus
    logic [cot_pkg::IdW-1:0]           pool[$];
    bit                                id_taken[logic [cot_pkg::IdW-1:0]];
    logic [cot_pkg::IdW-1:0]           id;
    logic signed [cot_pkg::RatioW-1:0] r;
    cot_pkg::cmd_e                     c;
    int unsigned                       pick;

    cmd_if.valid        = 1'b0;
    cmd_if.cmd          = cot_pkg::CmdSet;
    cmd_if.agent_key    = '0;
    cmd_if.offset_ratio = '0;
    rsp_if.ready        = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      slot_id[i]    = '0;
      slot_ratio[i] = '0;
    end

    // reserved id, absent ids, ratio extremes, update and insert
    add_cmd(cot_pkg::CmdSet, '0, 32'sd5);
    add_cmd(cot_pkg::CmdGet, '0, $urandom());
    add_cmd(cot_pkg::CmdGet, 16'h1234, $urandom());
    add_cmd(cot_pkg::CmdSet, 16'hFFFF, 32'sh8000_0000);
    add_cmd(cot_pkg::CmdSet, 16'h0001, 32'sh7FFF_FFFF);
    add_cmd(cot_pkg::CmdGet, 16'hFFFF, $urandom());
    add_cmd(cot_pkg::CmdGet, 16'h0001, $urandom());
    add_cmd(cot_pkg::CmdSet, 16'hFFFF, 32'sd0);
    add_cmd(cot_pkg::CmdGet, 16'hFFFF, $urandom());
    add_cmd(cot_pkg::CmdSet, 16'h5555, 32'sh4000_0000);
    add_cmd(cot_pkg::CmdGet, 16'h5555, $urandom());
    add_cmd(cot_pkg::CmdSet, 16'hAAAA, -32'sd1);
    add_cmd(cot_pkg::CmdGet, 16'hAAAA, $urandom());
    add_cmd(cot_pkg::CmdSet, '0, 32'sh7FFF_FFFF);
    add_cmd(cot_pkg::CmdGet, 16'h8000, $urandom());
    add_cmd(cot_pkg::CmdSet, 16'h5555, 32'shC000_0000);
    add_cmd(cot_pkg::CmdGet, 16'h5555, $urandom());

    // pool a little larger than the table so it fills and then drops sets
    pool = '{16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};
    foreach (pool[i]) id_taken[pool[i]] = 1'b1;
    while (pool.size() < PoolSize) begin
      id = cot_pkg::IdW'($urandom_range(1, 16'hFFFF));
      if (!id_taken.exists(id)) begin
        id_taken[id] = 1'b1;
        pool.push_back(id);
      end
    end

    for (int n = 0; n < NumRandom; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)      id = cot_pkg::IdW'($urandom());
      else if (pick < 7) id = '0;
      else               id = pool[$urandom_range(0, PoolSize - 1)];
      c = ($urandom_range(0, 1) == 1) ? cot_pkg::CmdGet : cot_pkg::CmdSet;
      case ($urandom_range(0, 9))
        0:       r = 32'sh8000_0000;
        1:       r = 32'sh7FFF_FFFF;
        2:       r = 32'sh4000_0000;
        default: r = $urandom();
      endcase
      add_cmd(c, id, r, n == 0 || n == NumRandom / 2);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || cmd_if.valid || reply_q.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/cot_pkg.sv
design/cot_if.sv
design/cot_store.sv
design/cot_ctrl.sv
design/clock_offset_table.sv
test/clock_offset_table_test.sv
